// ===== sv/assert_macros.svh =====
// Assertion macros used by the adaptive step size controller core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSC_ASSERT(lbl, prop, msg)
`define ASSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/assc_pkg.sv =====
// Package with types and constants of the adaptive step size controller.
package assc_pkg;

    localparam int FRAC_BITS_DEF  = 32;
    localparam int INT_BITS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 10;

    localparam int          K_BITS  = 13;
    localparam logic [12:0] MUL_DEN = 13'd8000;
    localparam logic [12:0] MUL_NUM = 13'd6859;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 3'd5;

    localparam logic [63:0] TOL_RST      = 64'd429497;
    localparam logic [63:0] LIMIT_RST    = 64'd429496730;
    localparam logic [63:0] INIT_RST     = 64'd42949673;
    localparam logic [63:0] INTERVAL_RST = 64'd4294967296;
    localparam logic [63:0] BIN_RST      = 64'd4294967;
    localparam logic [63:0] TOTAL_RST    = 64'd10;

    localparam logic ACTION_START = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_NEXT,
        ST_DIV,
        ST_ROOT_INIT,
        ST_ROOT_SHIFT,
        ST_ROOT_T,
        ST_ROOT_B,
        ST_ROOT_CMP,
        ST_ROOT_UPD,
        ST_CLAMP,
        ST_DIFF,
        ST_CHECK,
        ST_GUARD1,
        ST_GUARD2,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PASS_DEN,
        PASS_SQ,
        PASS_CUBE,
        PASS_TOL,
        PASS_NUM,
        PASS_TGT
    } pass_t;

endpackage

// ===== sv/assc_addsub.sv =====
// Shared wide adder and subtractor with carry in and carry out.
module assc_addsub #(
    parameter int W = 8
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    input  logic         cin,
    output logic [W-1:0] sum,
    output logic         cout
);

    logic [W:0] total;

    assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, cin};
    assign sum   = total[W-1:0];
    assign cout  = total[W];

endmodule

// ===== sv/assc_core.sv =====
// Sequencer and datapath that adapt the step and track flow time and measurements.
`include "assert_macros.svh"
module assc_core #(
    parameter int FRAC_BITS  = assc_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS   = assc_pkg::INT_BITS_DEF,
    parameter int COUNT_BITS = assc_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_action,
    input  logic [INT_BITS+FRAC_BITS-1:0] in_error,
    input  logic [INT_BITS+FRAC_BITS-1:0] tolerance,
    input  logic [INT_BITS+FRAC_BITS-1:0] step_limit,
    input  logic [INT_BITS+FRAC_BITS-1:0] initial_step,
    input  logic [INT_BITS+FRAC_BITS-1:0] measure_interval,
    input  logic [INT_BITS+FRAC_BITS-1:0] target_window,
    input  logic [COUNT_BITS-1:0]         measure_total,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          res_accepted,
    output logic [INT_BITS+FRAC_BITS-1:0] res_flow_time,
    output logic [INT_BITS+FRAC_BITS-1:0] res_next_step,
    output logic                          res_measure_now,
    output logic [COUNT_BITS-1:0]         res_measure_index,
    output logic                          res_run_done
);

    import assc_pkg::*;

    localparam int TW   = INT_BITS + FRAC_BITS;
    localparam int CW   = COUNT_BITS;
    localparam int RW   = 4 * TW + K_BITS;
    localparam int DW   = TW + K_BITS;
    localparam int XW   = 3 * TW;
    localparam int T2W  = 2 * TW + 2;
    localparam int CNTW = $clog2(RW + 1);

    state_t            state_reg, state_next;
    pass_t             pass_reg, pass_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [RW-1:0]     p_reg, p_next;
    logic [RW-1:0]     a_reg, a_next;
    logic [TW-1:0]     b_reg, b_next;
    logic [DW-1:0]     d_reg, d_next;
    logic [TW-1:0]     y_reg, y_next;
    logic [2*TW-1:0]   y2_reg, y2_next;
    logic [T2W-1:0]    t_reg, t_next;
    logic              big_reg, big_next;
    logic [TW-1:0]     time_reg, time_next;
    logic [TW-1:0]     step_reg, step_next;
    logic [CW-1:0]     taken_reg, taken_next;
    logic [TW-1:0]     target_reg, target_next;
    logic [TW-1:0]     diff_reg, diff_next;
    logic [TW-1:0]     lhs_reg, lhs_next;
    logic [TW-1:0]     rhs_reg, rhs_next;
    logic              acc_reg, acc_next;
    logic              meas_reg, meas_next;
    logic [CW-1:0]     idx_reg, idx_next;

    logic [RW-1:0]     add_a, add_b, add_sum;
    logic              add_sub, add_cin, add_cout;
    logic [RW-1:0]     rem_sh;
    logic [TW-1:0]     root_val;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] x, input logic [TW-1:0] y);
        logic [TW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    assc_addsub #(
        .W(RW)
    ) u_addsub (
        .a   (add_a),
        .b   (add_b),
        .sub (add_sub),
        .cin (add_cin),
        .sum (add_sum),
        .cout(add_cout)
    );

    assign rem_sh   = {a_reg[RW-2:0], p_reg[RW-1]};
    assign root_val = big_reg ? step_limit : ((y_reg > step_limit) ? step_limit : y_reg);

    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        cnt_next    = cnt_reg;
        p_next      = p_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        d_next      = d_reg;
        y_next      = y_reg;
        y2_next     = y2_reg;
        t_next      = t_reg;
        big_next    = big_reg;
        time_next   = time_reg;
        step_next   = step_reg;
        taken_next  = taken_reg;
        target_next = target_reg;
        diff_next   = diff_reg;
        lhs_next    = lhs_reg;
        rhs_next    = rhs_reg;
        acc_next    = acc_reg;
        meas_next   = meas_reg;
        idx_next    = idx_reg;
        add_a       = '0;
        add_b       = '0;
        add_sub     = 1'b0;
        add_cin     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next  = 1'b0;
                    meas_next = 1'b0;
                    idx_next  = '0;
                    if (in_action == ACTION_START)
                    begin
                        time_next  = '0;
                        taken_next = '0;
                        step_next  = initial_step;
                        state_next = ST_DONE;
                    end
                    else if (taken_reg >= measure_total)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        acc_next = (in_error < tolerance);
                        if (in_error < tolerance)
                        begin
                            time_next = sat_add(time_reg, step_reg);
                        end
                        p_next     = '0;
                        a_next     = (in_error == '0) ? RW'(1) : RW'(in_error);
                        b_next     = TW'(MUL_DEN);
                        cnt_next   = CNTW'(TW);
                        pass_next  = PASS_DEN;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                add_a = p_reg;
                add_b = a_reg;
                if (b_reg[0])
                begin
                    p_next = add_sum;
                end
                a_next   = {a_reg[RW-2:0], 1'b0};
                b_next   = {1'b0, b_reg[TW-1:1]};
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                cnt_next   = CNTW'(TW);
                state_next = ST_MUL;
                unique case (pass_reg)
                    PASS_DEN:
                    begin
                        d_next    = p_reg[DW-1:0];
                        p_next    = '0;
                        a_next    = RW'(step_reg);
                        b_next    = step_reg;
                        pass_next = PASS_SQ;
                    end
                    PASS_SQ:
                    begin
                        a_next    = p_reg;
                        p_next    = '0;
                        b_next    = step_reg;
                        pass_next = PASS_CUBE;
                    end
                    PASS_CUBE:
                    begin
                        a_next    = p_reg;
                        p_next    = '0;
                        b_next    = tolerance;
                        pass_next = PASS_TOL;
                    end
                    PASS_TOL:
                    begin
                        a_next    = p_reg;
                        p_next    = '0;
                        b_next    = TW'(MUL_NUM);
                        pass_next = PASS_NUM;
                    end
                    PASS_NUM:
                    begin
                        a_next     = '0;
                        cnt_next   = CNTW'(RW);
                        state_next = ST_DIV;
                    end
                    PASS_TGT:
                    begin
                        target_next = (|p_reg[RW-1:TW]) ? {TW{1'b1}} : p_reg[TW-1:0];
                        state_next  = ST_DIFF;
                    end
                    default:
                    begin
                        state_next = ST_DIFF;
                    end
                endcase
            end
            ST_DIV:
            begin
                add_a    = rem_sh;
                add_b    = RW'(d_reg);
                add_sub  = 1'b1;
                add_cin  = 1'b1;
                a_next   = add_cout ? add_sum : rem_sh;
                p_next   = {p_reg[RW-2:0], add_cout};
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT:
            begin
                big_next   = |p_reg[RW-1:XW];
                a_next     = '0;
                y_next     = '0;
                y2_next    = '0;
                cnt_next   = CNTW'(TW);
                state_next = (|p_reg[RW-1:XW]) ? ST_CLAMP : ST_ROOT_SHIFT;
            end
            ST_ROOT_SHIFT:
            begin
                a_next     = {a_reg[RW-4:0], p_reg[XW-1 -: 3]};
                p_next     = {p_reg[RW-4:0], 3'b000};
                y_next     = {y_reg[TW-2:0], 1'b0};
                y2_next    = {y2_reg[2*TW-3:0], 2'b00};
                cnt_next   = cnt_reg - CNTW'(1);
                state_next = ST_ROOT_T;
            end
            ST_ROOT_T:
            begin
                add_a      = RW'(y2_reg);
                add_b      = RW'(y_reg);
                t_next     = add_sum[T2W-1:0];
                state_next = ST_ROOT_B;
            end
            ST_ROOT_B:
            begin
                add_a      = RW'(t_reg);
                add_b      = RW'({t_reg, 1'b0});
                add_cin    = 1'b1;
                t_next     = add_sum[T2W-1:0];
                state_next = ST_ROOT_CMP;
            end
            ST_ROOT_CMP:
            begin
                add_a   = a_reg;
                add_b   = RW'(t_reg);
                add_sub = 1'b1;
                add_cin = 1'b1;
                if (add_cout)
                begin
                    a_next     = add_sum;
                    state_next = ST_ROOT_UPD;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = ST_CLAMP;
                end
                else
                begin
                    state_next = ST_ROOT_SHIFT;
                end
            end
            ST_ROOT_UPD:
            begin
                add_a      = RW'(y2_reg);
                add_b      = RW'({y_reg, 1'b0});
                add_cin    = 1'b1;
                y2_next    = add_sum[2*TW-1:0];
                y_next     = {y_reg[TW-1:1], 1'b1};
                state_next = (cnt_reg == '0) ? ST_CLAMP : ST_ROOT_SHIFT;
            end
            ST_CLAMP:
            begin
                step_next  = (root_val == '0) ? TW'(1) : root_val;
                p_next     = '0;
                a_next     = RW'(measure_interval);
                b_next     = TW'(taken_reg) + TW'(1);
                cnt_next   = CNTW'(CW);
                pass_next  = PASS_TGT;
                state_next = ST_MUL;
            end
            ST_DIFF:
            begin
                diff_next  = (time_reg >= target_reg) ? (time_reg - target_reg)
                                                      : (target_reg - time_reg);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (acc_reg && (diff_reg <= target_window))
                begin
                    meas_next   = 1'b1;
                    idx_next    = taken_reg;
                    taken_next  = taken_reg + CW'(1);
                    target_next = sat_add(target_reg, measure_interval);
                end
                state_next = ST_GUARD1;
            end
            ST_GUARD1:
            begin
                lhs_next   = sat_add(time_reg, step_reg);
                rhs_next   = sat_add(target_reg, target_window);
                state_next = ST_GUARD2;
            end
            ST_GUARD2:
            begin
                if ((lhs_reg > rhs_reg) && (target_reg > time_reg))
                begin
                    step_next = target_reg - time_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            time_reg  <= '0;
            step_reg  <= '0;
            taken_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            time_reg  <= time_next;
            step_reg  <= step_next;
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg   <= pass_next;
        cnt_reg    <= cnt_next;
        p_reg      <= p_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        d_reg      <= d_next;
        y_reg      <= y_next;
        y2_reg     <= y2_next;
        t_reg      <= t_next;
        big_reg    <= big_next;
        target_reg <= target_next;
        diff_reg   <= diff_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
        acc_reg    <= acc_next;
        meas_reg   <= meas_next;
        idx_reg    <= idx_next;
    end

    assign in_ready          = (state_reg == ST_IDLE);
    assign res_valid         = (state_reg == ST_DONE);
    assign res_accepted      = acc_reg;
    assign res_flow_time     = time_reg;
    assign res_next_step     = step_reg;
    assign res_measure_now   = meas_reg;
    assign res_measure_index = idx_reg;
    assign res_run_done      = (taken_reg >= measure_total);

    `ASSC_ASSERT(a_div_rem, (state_reg == ST_DIV) |-> (a_reg < RW'(d_reg)), "remainder not below divisor")
    `ASSC_ASSERT(a_step_min, (state_reg == ST_CLAMP) |=> (step_reg != '0), "adapted step is zero")
    `ASSC_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(time_reg) && $stable(step_reg) && $stable(acc_reg)), "result changed while stalled")
    `ASSC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_reg == ST_IDLE), "sequencer busy after reset")

endmodule

// ===== sv/adaptive_step_size_controller.sv =====
// An error word on the input stream with tuser high is one integrator attempt; tuser low starts
// a run. Start words and attempts after the run is done go straight to the result. Other
// attempts run the exact cube root step update through one shared adder under a sequencer:
// five shift and add multiplies, a restoring divide over 4*TW+13 quotient bits and a digit by
// digit cube root, then the target multiply and the checks. TW is INT_BITS + FRAC_BITS, with
// Q8.32 time and a ten bit count by default. The block takes one word at a time; the output
// register lets a new word enter while a result waits.
module adaptive_step_size_controller #(
    parameter int FRAC_BITS  = assc_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS   = assc_pkg::INT_BITS_DEF,
    parameter int COUNT_BITS = assc_pkg::COUNT_BITS_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               s_tvalid,
    output logic                                               s_tready,
    // step_error
    input  logic [((INT_BITS+FRAC_BITS+7)/8)*8-1:0]            s_tdata,
    // action
    input  logic                                               s_tuser,
    output logic                                               m_tvalid,
    input  logic                                               m_tready,
    // accepted, flow_time, next_step, measure_now, measure_index, run_done
    output logic [((2*(INT_BITS+FRAC_BITS)+COUNT_BITS+3+7)/8)*8-1:0] m_tdata,
    input  logic                                               cfg_valid,
    output logic                                               cfg_ready,
    input  logic [assc_pkg::CFG_IDX_W-1:0]                     cfg_index,
    input  logic [INT_BITS+FRAC_BITS-1:0]                      cfg_data
);

    import assc_pkg::*;

    localparam int TW    = INT_BITS + FRAC_BITS;
    localparam int CW    = COUNT_BITS;
    localparam int OUT_W = ((2 * TW + CW + 3 + 7) / 8) * 8;

    logic [TW-1:0]    tol_reg, limit_reg, init_reg, interval_reg, bin_reg;
    logic [CW-1:0]    total_reg;
    logic             res_valid, res_ready;
    logic             res_accepted, res_measure_now, res_run_done;
    logic [TW-1:0]    res_flow_time, res_next_step;
    logic [CW-1:0]    res_measure_index;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    assc_core #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_action        (s_tuser),
        .in_error         (s_tdata[TW-1:0]),
        .tolerance        (tol_reg),
        .step_limit       (limit_reg),
        .initial_step     (init_reg),
        .measure_interval (interval_reg),
        .target_window    (bin_reg),
        .measure_total    (total_reg),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res_accepted     (res_accepted),
        .res_flow_time    (res_flow_time),
        .res_next_step    (res_next_step),
        .res_measure_now  (res_measure_now),
        .res_measure_index(res_measure_index),
        .res_run_done     (res_run_done)
    );

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= TW'(TOL_RST);
            limit_reg     <= TW'(LIMIT_RST);
            init_reg      <= TW'(INIT_RST);
            interval_reg  <= TW'(INTERVAL_RST);
            bin_reg       <= TW'(BIN_RST);
            total_reg     <= CW'(TOTAL_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_TOLERANCE:     tol_reg      <= cfg_data;
                    REG_STEP_LIMIT:    limit_reg    <= cfg_data;
                    REG_INITIAL_STEP:  init_reg     <= cfg_data;
                    REG_INTERVAL:      interval_reg <= cfg_data;
                    REG_TARGET_WINDOW: bin_reg      <= cfg_data;
                    REG_TOTAL:         total_reg    <= cfg_data[CW-1:0];
                    default:           ;
                endcase
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= OUT_W'({res_run_done, res_measure_index, res_measure_now,
                                    res_next_step, res_flow_time, res_accepted});
        end
    end

endmodule
